// File: rtl/core/http_request_header_parser_assert.svh
// ----------------------------------------------------------------------------
// HTTP request header parser assertion macros
// Shorthand for the concurrent checks used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HRHP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrhp: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define HRHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrhp: next-cycle check failed");

`endif

// File: rtl/core/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Phase, verdict and role codes, character classes and the version digit
// accumulator shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

   localparam int VER_BITS = 16;
   localparam int VER_SUM_BITS = VER_BITS + 4;
   localparam logic [VER_SUM_BITS-1:0] VER_MAX = {{4{1'b0}}, {VER_BITS{1'b1}}};

   typedef logic [VER_BITS-1:0] ver_type;

   typedef enum logic [4:0] {
      PH_METHOD_START = 5'd0,
      PH_METHOD       = 5'd1,
      PH_URI_START    = 5'd2,
      PH_URI          = 5'd3,
      PH_H            = 5'd4,
      PH_T1           = 5'd5,
      PH_T2           = 5'd6,
      PH_P            = 5'd7,
      PH_SLASH        = 5'd8,
      PH_MAJ_START    = 5'd9,
      PH_MAJ          = 5'd10,
      PH_MIN_START    = 5'd11,
      PH_MIN          = 5'd12,
      PH_NL1          = 5'd13,
      PH_LINE_START   = 5'd14,
      PH_LWS          = 5'd15,
      PH_NAME         = 5'd16,
      PH_SP_VALUE     = 5'd17,
      PH_VALUE        = 5'd18,
      PH_NL2          = 5'd19,
      PH_NL3          = 5'd20,
      PH_DONE_OK      = 5'd21,
      PH_DONE_BAD     = 5'd22
   } phase_type;

   typedef enum logic [1:0] {
      V_MORE = 2'd0,
      V_OK   = 2'd1,
      V_BAD  = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      R_DELIM    = 3'd0,
      R_METHOD   = 3'd1,
      R_URI      = 3'd2,
      R_NEW_NAME = 3'd3,
      R_NAME     = 3'd4,
      R_VALUE    = 3'd5
   } role_type;

   typedef struct packed {
      phase_type phase;
      logic      header_seen;
      ver_type   major;
      ver_type   minor;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:       PH_METHOD_START,
      header_seen: 1'b0,
      major:       '0,
      minor:       '0
   };

   localparam logic [7:0] CH_HT      = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_SP      = 8'h20;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_SLASH   = 8'h2f;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_COLON   = 8'h3a;
   localparam logic [7:0] CH_H       = 8'h48;
   localparam logic [7:0] CH_P       = 8'h50;
   localparam logic [7:0] CH_T       = 8'h54;
   localparam logic [7:0] CH_CTL_MAX = 8'd31;
   localparam logic [7:0] CH_DEL     = 8'd127;

   function automatic logic is_ctl(input logic [7:0] c);
      return (c <= CH_CTL_MAX) || (c == CH_DEL);
   endfunction

   function automatic logic is_special(input logic [7:0] c);
      logic hit;
      case (c) inside
         8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
         8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09:
            hit = 1'b1;
         default:
            hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic is_token(input logic [7:0] c);
      return (c <= CH_DEL) && !is_ctl(c) && !is_special(c);
   endfunction

   function automatic logic is_decimal(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // acc * 10 + digit as two shifted adds, clamped at the all-ones value.
   function automatic ver_type add_digit(input ver_type acc, input logic [7:0] c);
      logic [VER_SUM_BITS-1:0] wide;
      logic [VER_SUM_BITS-1:0] sum;
      logic [7:0]              digit;
      wide  = {{4{1'b0}}, acc};
      digit = c - CH_ZERO;
      sum   = (wide << 3) + (wide << 1) + {{(VER_SUM_BITS-4){1'b0}}, digit[3:0]};
      return (sum > VER_MAX) ? {VER_BITS{1'b1}} : sum[VER_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/hrhp_step.sv
// ----------------------------------------------------------------------------
// HTTP request header parser step logic
// Combinational grammar transition for one request byte: next parser state,
// verdict and role of the byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrhp_step (
   input  hrhp_pkg::parse_state_type cur_state,
   input  logic [7:0]                data_byte,
   input  logic                      restart,
   output hrhp_pkg::parse_state_type nxt_state,
   output hrhp_pkg::verdict_type     verdict,
   output hrhp_pkg::role_type        byte_role
);

   hrhp_pkg::parse_state_type st;
   hrhp_pkg::parse_state_type nx;
   hrhp_pkg::verdict_type     vd;
   hrhp_pkg::role_type        rl;
   logic                      bad;
   logic                      is_ws;

   assign is_ws = (data_byte == hrhp_pkg::CH_SP) || (data_byte == hrhp_pkg::CH_HT);

   always_comb begin
      st  = restart ? hrhp_pkg::STATE_RESET : cur_state;
      nx  = st;
      vd  = hrhp_pkg::V_MORE;
      rl  = hrhp_pkg::R_DELIM;
      bad = 1'b0;
      unique case (st.phase)
         hrhp_pkg::PH_METHOD_START: begin
            if (hrhp_pkg::is_token(data_byte)) begin
               nx.phase = hrhp_pkg::PH_METHOD;
               rl       = hrhp_pkg::R_METHOD;
            end else begin
               bad = 1'b1;
            end
         end
         hrhp_pkg::PH_METHOD: begin
            if (data_byte == hrhp_pkg::CH_SP) nx.phase = hrhp_pkg::PH_URI_START;
            else if (hrhp_pkg::is_token(data_byte)) rl = hrhp_pkg::R_METHOD;
            else bad = 1'b1;
         end
         hrhp_pkg::PH_URI_START: begin
            if (hrhp_pkg::is_ctl(data_byte)) begin
               bad = 1'b1;
            end else begin
               nx.phase = hrhp_pkg::PH_URI;
               rl       = hrhp_pkg::R_URI;
            end
         end
         hrhp_pkg::PH_URI: begin
            if (data_byte == hrhp_pkg::CH_SP) nx.phase = hrhp_pkg::PH_H;
            else if (hrhp_pkg::is_ctl(data_byte)) bad = 1'b1;
            else rl = hrhp_pkg::R_URI;
         end
         hrhp_pkg::PH_H: begin
            if (data_byte == hrhp_pkg::CH_H) nx.phase = hrhp_pkg::PH_T1;
            else bad = 1'b1;
         end
         hrhp_pkg::PH_T1: begin
            if (data_byte == hrhp_pkg::CH_T) nx.phase = hrhp_pkg::PH_T2;
            else bad = 1'b1;
         end
         hrhp_pkg::PH_T2: begin
            if (data_byte == hrhp_pkg::CH_T) nx.phase = hrhp_pkg::PH_P;
            else bad = 1'b1;
         end
         hrhp_pkg::PH_P: begin
            if (data_byte == hrhp_pkg::CH_P) nx.phase = hrhp_pkg::PH_SLASH;
            else bad = 1'b1;
         end
         hrhp_pkg::PH_SLASH: begin
            if (data_byte == hrhp_pkg::CH_SLASH) begin
               nx.major = '0;
               nx.minor = '0;
               nx.phase = hrhp_pkg::PH_MAJ_START;
            end else begin
               bad = 1'b1;
            end
         end
         hrhp_pkg::PH_MAJ_START: begin
            if (hrhp_pkg::is_decimal(data_byte)) begin
               nx.major = hrhp_pkg::add_digit(st.major, data_byte);
               nx.phase = hrhp_pkg::PH_MAJ;
            end else begin
               bad = 1'b1;
            end
         end
         hrhp_pkg::PH_MAJ: begin
            if (data_byte == hrhp_pkg::CH_DOT) begin
               nx.phase = hrhp_pkg::PH_MIN_START;
            end else if (hrhp_pkg::is_decimal(data_byte)) begin
               nx.major = hrhp_pkg::add_digit(st.major, data_byte);
            end else begin
               bad = 1'b1;
            end
         end
         hrhp_pkg::PH_MIN_START: begin
            if (hrhp_pkg::is_decimal(data_byte)) begin
               nx.minor = hrhp_pkg::add_digit(st.minor, data_byte);
               nx.phase = hrhp_pkg::PH_MIN;
            end else begin
               bad = 1'b1;
            end
         end
         hrhp_pkg::PH_MIN: begin
            if (data_byte == hrhp_pkg::CH_CR) begin
               nx.phase = hrhp_pkg::PH_NL1;
            end else if (hrhp_pkg::is_decimal(data_byte)) begin
               nx.minor = hrhp_pkg::add_digit(st.minor, data_byte);
            end else begin
               bad = 1'b1;
            end
         end
         hrhp_pkg::PH_NL1: begin
            if (data_byte == hrhp_pkg::CH_LF) nx.phase = hrhp_pkg::PH_LINE_START;
            else bad = 1'b1;
         end
         hrhp_pkg::PH_LINE_START: begin
            if (data_byte == hrhp_pkg::CH_CR) begin
               nx.phase = hrhp_pkg::PH_NL3;
            end else if (st.header_seen && is_ws) begin
               nx.phase = hrhp_pkg::PH_LWS;
            end else if (hrhp_pkg::is_token(data_byte)) begin
               nx.header_seen = 1'b1;
               nx.phase       = hrhp_pkg::PH_NAME;
               rl             = hrhp_pkg::R_NEW_NAME;
            end else begin
               bad = 1'b1;
            end
         end
         hrhp_pkg::PH_LWS: begin
            if (data_byte == hrhp_pkg::CH_CR) begin
               nx.phase = hrhp_pkg::PH_NL2;
            end else if (is_ws) begin
               nx.phase = hrhp_pkg::PH_LWS;
            end else if (hrhp_pkg::is_ctl(data_byte)) begin
               bad = 1'b1;
            end else begin
               nx.phase = hrhp_pkg::PH_VALUE;
               rl       = hrhp_pkg::R_VALUE;
            end
         end
         hrhp_pkg::PH_NAME: begin
            if (data_byte == hrhp_pkg::CH_COLON) nx.phase = hrhp_pkg::PH_SP_VALUE;
            else if (hrhp_pkg::is_token(data_byte)) rl = hrhp_pkg::R_NAME;
            else bad = 1'b1;
         end
         hrhp_pkg::PH_SP_VALUE: begin
            if (data_byte == hrhp_pkg::CH_SP) nx.phase = hrhp_pkg::PH_VALUE;
            else bad = 1'b1;
         end
         hrhp_pkg::PH_VALUE: begin
            if (data_byte == hrhp_pkg::CH_CR) nx.phase = hrhp_pkg::PH_NL2;
            else if (hrhp_pkg::is_ctl(data_byte)) bad = 1'b1;
            else rl = hrhp_pkg::R_VALUE;
         end
         hrhp_pkg::PH_NL2: begin
            if (data_byte == hrhp_pkg::CH_LF) nx.phase = hrhp_pkg::PH_LINE_START;
            else bad = 1'b1;
         end
         hrhp_pkg::PH_NL3: begin
            if (data_byte == hrhp_pkg::CH_LF) begin
               nx.phase = hrhp_pkg::PH_DONE_OK;
               vd       = hrhp_pkg::V_OK;
            end else begin
               bad = 1'b1;
            end
         end
         hrhp_pkg::PH_DONE_OK: begin
            vd = hrhp_pkg::V_OK;
         end
         default: begin
            // The held bad phase and any code outside the grammar.
            bad = 1'b1;
         end
      endcase

      if (bad) begin
         nx.phase = hrhp_pkg::PH_DONE_BAD;
         vd       = hrhp_pkg::V_BAD;
         rl       = hrhp_pkg::R_DELIM;
      end
   end

   assign nxt_state = nx;
   assign verdict   = vd;
   assign byte_role = rl;

endmodule

`default_nettype wire

// File: rtl/core/http_request_header_parser.sv
// Path: an accepted word passes through the input register and then the result
// register before it can be taken on the response side. Throughput: one word
// per cycle unless the response stalls; the grammar step between the registers is
// a combinational state transition plus a shift-add version accumulator.
// Reset: synchronous, active high; it empties both stages and returns the parser
// to the method-start phase with the header flag and both versions at zero.
// ----------------------------------------------------------------------------
// HTTP request header parser
// Walks the HTTP/major.minor request line and header grammar one byte per word and
// tags each byte with a verdict, a role and the running version numbers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "http_request_header_parser_assert.svh"

module http_request_header_parser (
   input  logic        clock,
   input  logic        reset,

   // Request stream: one request byte per word.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] restart

   // Response stream: one parse result per request word.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [1:0] verdict, [9:2] echo_byte,
                                    // [25:10] major_version, [41:26] minor_version,
                                    // [47:42] zero
   output logic [2:0]  rsp_tuser    // [2:0] byte_role
);

   // Input register. It holds a word until the grammar step can commit it.
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic [7:0]                s1_byte_ff;
   logic                      s1_restart_ff;

   // Parser state. It only changes when a word moves into the result register,
   // so a stalled response never lets the grammar run ahead.
   hrhp_pkg::parse_state_type state_ff;
   hrhp_pkg::parse_state_type state_in;

   // Result register.
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   hrhp_pkg::verdict_type     rsp_verdict_ff;
   hrhp_pkg::role_type        rsp_role_ff;
   logic [7:0]                rsp_byte_ff;
   hrhp_pkg::ver_type         rsp_major_ff;
   hrhp_pkg::ver_type         rsp_minor_ff;

   hrhp_pkg::parse_state_type step_state;
   hrhp_pkg::verdict_type     step_verdict;
   hrhp_pkg::role_type        step_role;
   logic                      advance;
   logic                      req_fire;

   // Terms used by the checks at the end of the module.
   logic                      role_tagged;
   logic                      ok_step;
   logic                      ok_held;
   logic                      bad_step;
   logic                      bad_held;
   logic                      s1_stall;
   logic [8:0]                s1_payload;

   hrhp_step u_step (
      .cur_state (state_ff),
      .data_byte (s1_byte_ff),
      .restart   (s1_restart_ff),
      .nxt_state (step_state),
      .verdict   (step_verdict),
      .byte_role (step_role)
   );

   // A word leaves the input register whenever the result register is empty
   // or is being drained in this cycle; the input register then takes the next
   // word in the same cycle, which keeps the stream at one word per cycle.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
      state_in     = advance ? step_state : state_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= hrhp_pkg::STATE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers need no reset; they are qualified by the valid flags.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff    <= req_tdata;
         s1_restart_ff <= req_tuser;
      end
      if (advance) begin
         rsp_verdict_ff <= step_verdict;
         rsp_role_ff    <= step_role;
         rsp_byte_ff    <= s1_byte_ff;
         rsp_major_ff   <= step_state.major;
         rsp_minor_ff   <= step_state.minor;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_minor_ff, rsp_major_ff, rsp_byte_ff, rsp_verdict_ff};
   assign rsp_tuser  = rsp_role_ff;

   assign role_tagged = rsp_valid_ff && (rsp_role_ff != hrhp_pkg::R_DELIM);
   assign ok_step     = advance && !s1_restart_ff && (state_ff.phase == hrhp_pkg::PH_DONE_OK);
   assign ok_held     = (state_ff.phase == hrhp_pkg::PH_DONE_OK)
                        && (rsp_verdict_ff == hrhp_pkg::V_OK);
   assign bad_step    = advance && !s1_restart_ff && (state_ff.phase == hrhp_pkg::PH_DONE_BAD);
   assign bad_held    = (rsp_verdict_ff == hrhp_pkg::V_BAD);
   assign s1_stall    = s1_valid_ff && !advance;
   assign s1_payload  = {s1_restart_ff, s1_byte_ff};

   // A byte that carries a text role is never the one that ends the request.
   `HRHP_ASSERT_IMP(a_role_means_more, clock, reset, role_tagged, rsp_verdict_ff == hrhp_pkg::V_MORE)

   // A finished request stays finished until a restart arrives.
   `HRHP_ASSERT_NEXT(a_done_ok_holds, clock, reset, ok_step, ok_held)

   // A malformed request keeps its versions and its verdict until a restart.
   `HRHP_ASSERT_NEXT(a_done_bad_holds, clock, reset, bad_step, bad_held && $stable(state_ff))

   // A word waiting in the input register is neither lost nor overwritten.
   `HRHP_ASSERT_NEXT(a_input_held, clock, reset, s1_stall, s1_valid_ff && $stable(s1_payload))

endmodule

`default_nettype wire
